>>> rtl/core/activation_function_unit_defines.svh
// assertion macros for the activation function unit checker
// no dependencies
`ifndef ACTIVATION_FUNCTION_UNIT_DEFINES_SVH
`define ACTIVATION_FUNCTION_UNIT_DEFINES_SVH

// checked only out of reset
`define AFU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/afu_pkg.sv
// shared types, constants and elaboration functions of the activation function unit
// used by afu_exp, afu_div and activation_function_unit
package afu_pkg;

  typedef enum logic [2:0] {
    FN_BINARY  = 3'd0,
    FN_LINEAR  = 3'd1,
    FN_SIGMOID = 3'd2,
    FN_TANH    = 3'd3,
    FN_RELU    = 3'd4,
    FN_LEAKY   = 3'd5,
    FN_ELU     = 3'd6
  } func_t;

  typedef enum logic {
    REG_FSEL  = 1'b0,
    REG_DERIV = 1'b1
  } reg_t;

  localparam int XW     = 32;
  localparam int EW     = 33;
  localparam int DIV_NW = 63;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 31;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;

  typedef struct packed {
    func_t          fsel;
    logic           deriv;
    logic [XW-1:0]  x;
    logic [EW-1:0]  e;
  } ctx_t;

  // 2^(arg/2^30 / ln2) style series entry: e^arg in Q30
  function automatic logic [31:0] pow2_entry(input logic [63:0] arg);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * arg) >> 30) / 64'(k);
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

  function automatic logic [63:0] round_shift(input logic [63:0] v, input int unsigned sh);
    logic [63:0] res;
    if (sh == 0) begin
      res = v;
    end else begin
      res = (v + (64'd1 << (sh - 1))) >> sh;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/activation_function_unit.sv
// activation function unit top level: config registers, input skid, setup, post and output
// depends on afu_pkg, afu_exp and afu_div
// Takes one signed sample per clock and returns one saturated result per clock, in order,
// while the output is not stalled. From acceptance to out_valid an item passes four exp
// stages, one setup stage, the 31-stage radix-2 divider shared by sigmoid, tanh and leaky
// ReLU, one multiply stage and the output register. A stall on the output freezes the
// whole pipeline; one item already offered is held in a skid register, so in_stall rises
// once that register is full. Function code 7 returns zero. The user must write function
// and derivative selection over the APB port only while no item is in flight (not enforced).
module activation_function_unit import afu_pkg::*; #(
  parameter int DATA_WIDTH      = 16,
  parameter int FRAC_BITS       = 12,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_sample_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_result_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int RSW   = 35;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int TENTH = (ONE_I + 5) / 10;
  localparam logic signed [RSW-1:0] ONE_V   = RSW'(ONE_I);
  localparam logic signed [RSW-1:0] TENTH_V = RSW'(TENTH);
  localparam logic signed [RSW-1:0] SAT_HI  = RSW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [RSW-1:0] SAT_LO  = -SAT_HI - RSW'(1);
  localparam int unsigned SH30 = 30 - FRAC_BITS;
  localparam int unsigned SH32 = 32 - FRAC_BITS;

  // configuration
  logic [2:0] fsel_r;
  logic       deriv_r;
  logic       cfg_wr;
  reg_t       reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r  <= 3'd0;
      deriv_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FSEL:  fsel_r  <= pwdata[2:0];
        REG_DERIV: deriv_r <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FSEL:  prdata = 32'(fsel_r);
      REG_DERIV: prdata = 32'(deriv_r);
      default:   prdata = '0;
    endcase
  end

  // input skid and pipeline enable
  logic                  en;
  logic                  skid_full_r;
  logic [DATA_WIDTH-1:0] skid_r;
  logic                  out_valid_r;
  logic                  accept;
  logic                  src_valid;
  logic [DATA_WIDTH-1:0] src_sample;
  ctx_t                  src_ctx;

  assign en         = !out_valid_r || !out_stall;
  assign in_stall   = skid_full_r;
  assign accept     = in_valid && !skid_full_r;
  assign src_valid  = skid_full_r || in_valid;
  assign src_sample = skid_full_r ? skid_r : in_sample_in;

  always_comb begin
    src_ctx       = '0;
    src_ctx.fsel  = func_t'(fsel_r);
    src_ctx.deriv = deriv_r;
    src_ctx.x     = XW'($signed(src_sample));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= en ? 1'b0 : (skid_full_r || accept);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !en) begin
      skid_r <= in_sample_in;
    end
  end

  // exp pipeline
  logic          ve;
  ctx_t          ctx_e;
  logic [EW-1:0] e_e;

  afu_exp #(
    .FRAC_BITS      (FRAC_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (src_valid),
    .in_ctx   (src_ctx),
    .out_valid(ve),
    .out_ctx  (ctx_e),
    .out_e    (e_e)
  );

  // divider setup
  logic              vs_r;
  ctx_t              ctx_s_r;
  logic [DIV_NW-1:0] num_s_r;
  logic [DIV_DW-1:0] den_s_r;
  logic [DIV_NW-1:0] num_nxt;
  logic [DIV_DW-1:0] den_nxt;
  logic [DIV_DW-1:0] den_e;
  logic [XW:0]       xe;
  logic [XW-1:0]     axe;
  ctx_t              ctx_full;

  always_comb begin
    ctx_full   = ctx_e;
    ctx_full.e = e_e;
    xe    = {ctx_e.x[XW-1], ctx_e.x};
    axe   = xe[XW] ? XW'(-xe) : ctx_e.x;
    den_e = (DIV_DW'(1) << 32) + DIV_DW'(e_e);
    unique case (ctx_e.fsel)
      FN_SIGMOID: begin
        num_nxt = (DIV_NW'(1) << 62) + DIV_NW'(den_e >> 1);
        den_nxt = den_e;
      end
      FN_TANH: begin
        num_nxt = (DIV_NW'((EW'(1) << 32) - e_e) << 30) + DIV_NW'(den_e >> 1);
        den_nxt = den_e;
      end
      FN_LEAKY: begin
        num_nxt = DIV_NW'(axe) + DIV_NW'(5);
        den_nxt = DIV_DW'(10);
      end
      default: begin
        num_nxt = '0;
        den_nxt = DIV_DW'(1);
      end
    endcase
  end

  // post multiply and output
  logic              vq;
  ctx_t              ctx_q;
  logic [DIV_QW-1:0] q_q;
  logic              vf_r;
  ctx_t              ctx_f_r;
  logic [DIV_QW-1:0] q_f_r;
  logic [61:0]       mp_f_r;
  logic [61:0]       mp_nxt;
  logic [DATA_WIDTH-1:0] result_r;

  afu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vs_r),
    .in_num   (num_s_r),
    .in_den   (den_s_r),
    .in_ctx   (ctx_s_r),
    .out_valid(vq),
    .out_q    (q_q),
    .out_ctx  (ctx_q)
  );

  assign mp_nxt = (ctx_q.fsel == FN_SIGMOID)
                ? 62'(q_q) * 62'((DIV_QW'(1) << 30) - q_q)
                : 62'(q_q) * 62'(q_q);

  logic signed [RSW-1:0] r;
  logic signed [RSW-1:0] r_sat;
  logic signed [XW-1:0]  xf;
  logic [63:0]           dm;
  logic [DIV_QW-1:0]     s2;
  logic signed [RSW-1:0] rs_d;
  logic signed [RSW-1:0] rs_s;
  logic signed [RSW-1:0] rs_e;
  logic signed [RSW-1:0] rs_em;
  logic signed [RSW-1:0] rs_t;
  logic signed [RSW-1:0] rs_td;

  always_comb begin
    xf    = $signed(ctx_f_r.x);
    dm    = (64'(mp_f_r) + (64'd1 << 29)) >> 30;
    s2    = (xf < 0) ? (DIV_QW'(1) << 30) - q_f_r : q_f_r;
    rs_d  = RSW'(round_shift(dm, SH30));
    rs_s  = RSW'(round_shift(64'(s2), SH30));
    rs_t  = RSW'(round_shift(64'(q_f_r), SH30));
    rs_td = RSW'(round_shift((64'd1 << 30) - dm, SH30));
    rs_e  = RSW'(round_shift(64'(ctx_f_r.e), SH32));
    rs_em = RSW'(round_shift((64'd1 << 32) - 64'(ctx_f_r.e), SH32));
    case (ctx_f_r.fsel)
      FN_BINARY:  r = ctx_f_r.deriv ? '0 : ((xf < 0) ? '0 : ONE_V);
      FN_LINEAR:  r = ctx_f_r.deriv ? ONE_V : RSW'(xf);
      FN_SIGMOID: r = ctx_f_r.deriv ? rs_d : rs_s;
      FN_TANH:    r = ctx_f_r.deriv ? rs_td : ((xf < 0) ? -rs_t : rs_t);
      FN_RELU:    r = (xf > 0) ? (ctx_f_r.deriv ? ONE_V : RSW'(xf)) : '0;
      FN_LEAKY: begin
        if (ctx_f_r.deriv) begin
          r = (xf > 0) ? ONE_V : TENTH_V;
        end else begin
          r = (xf > 0) ? RSW'(xf) : -RSW'(q_f_r);
        end
      end
      FN_ELU: begin
        if (xf > 0) begin
          r = ctx_f_r.deriv ? ONE_V : RSW'(xf);
        end else begin
          r = ctx_f_r.deriv ? rs_e : -rs_em;
        end
      end
      default:    r = '0;
    endcase
    r_sat = (r > SAT_HI) ? SAT_HI : ((r < SAT_LO) ? SAT_LO : r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r        <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vs_r        <= ve;
      vf_r        <= vq;
      out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_s_r  <= ctx_full;
      num_s_r  <= num_nxt;
      den_s_r  <= den_nxt;
      ctx_f_r  <= ctx_q;
      q_f_r    <= q_q;
      mp_f_r   <= mp_nxt;
      result_r <= DATA_WIDTH'(r_sat);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_out = $signed(result_r);

endmodule

>>> rtl/core/afu_exp.sv
// four-stage e^-a pipeline: log2e scaling, rom lookup, interpolation, final shift
// depends on afu_pkg
module afu_exp import afu_pkg::*; #(
  parameter int FRAC_BITS       = 12,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ctx_t          in_ctx,
  output logic          out_valid,
  output ctx_t          out_ctx,
  output logic [EW-1:0] out_e
);

  localparam int AMW = FRAC_BITS + 5;
  localparam int MW  = AMW + 31;
  localparam int NW  = MW - FRAC_BITS - 30;
  localparam int IW  = $clog2(EXP_TABLE_DEPTH);
  localparam int PW  = 32 + IW;
  localparam int RW  = $clog2(EXP_TABLE_DEPTH + 1);

  logic [31:0] rom [EXP_TABLE_DEPTH+1];

  for (genvar i = 0; i <= EXP_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] ARG =
      (64'(i) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
    assign rom[i] = pow2_entry(ARG);
  end

  // stage a
  logic          va_r;
  ctx_t          ctx_a_r;
  logic [MW-1:0] m_a_r;
  logic          ovf_a_r;
  logic [XW:0]   xs;
  logic [XW-1:0] ax;
  logic [XW:0]   a;
  logic          ovf_a;
  logic [AMW-1:0] am;

  always_comb begin
    xs    = {in_ctx.x[XW-1], in_ctx.x};
    ax    = xs[XW] ? XW'(-xs) : in_ctx.x;
    a     = (in_ctx.fsel == FN_TANH) ? {ax, 1'b0} : {1'b0, ax};
    ovf_a = (a >> FRAC_BITS) >= (XW+1)'(32);
    am    = ovf_a ? '0 : AMW'(a);
  end

  // stage b
  logic          vb_r;
  ctx_t          ctx_b_r;
  logic [31:0]   lo_b_r;
  logic [31:0]   hi_b_r;
  logic [31:0]   rem_b_r;
  logic [NW-1:0] n_b_r;
  logic          frz_b_r;
  logic          ovf_b_r;
  logic [NW-1:0] n_b;
  logic [31:0]   fr;
  logic [31:0]   g;
  logic [PW-1:0] prod;
  logic [RW-1:0] idx;

  always_comb begin
    n_b  = m_a_r[MW-1:FRAC_BITS+30];
    fr   = m_a_r[FRAC_BITS+29:FRAC_BITS-2];
    g    = 32'd0 - fr;
    prod = PW'(g) * PW'(EXP_TABLE_DEPTH);
    idx  = RW'(prod[PW-1:32]);
  end

  // stage c
  logic          vc_r;
  ctx_t          ctx_c_r;
  logic [31:0]   lo_c_r;
  logic [63:0]   p_c_r;
  logic [NW-1:0] n_c_r;
  logic          frz_c_r;
  logic          ovf_c_r;

  // stage d
  logic          vd_r;
  ctx_t          ctx_d_r;
  logic [EW-1:0] e_d_r;
  logic [32:0]   pw;
  logic [63:0]   v;
  logic [6:0]    sh;
  logic [EW-1:0] e_frac;
  logic [EW-1:0] e_int;
  logic [EW-1:0] e_nxt;

  always_comb begin
    pw     = 33'(lo_c_r) + 33'((p_c_r + 64'h8000_0000) >> 32);
    v      = 64'(pw) << 2;
    sh     = 7'(n_c_r) + 7'd1;
    e_frac = (sh > 7'd40) ? '0 : EW'((v + (64'd1 << (sh - 7'd1))) >> sh);
    e_int  = EW'((64'd1 << 32) >> n_c_r);
    e_nxt  = ovf_c_r ? '0 : (frz_c_r ? e_int : e_frac);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a_r <= in_ctx;
      m_a_r   <= MW'(am) * MW'(LOG2E_Q30);
      ovf_a_r <= ovf_a;
      ctx_b_r <= ctx_a_r;
      lo_b_r  <= rom[idx];
      hi_b_r  <= rom[idx + RW'(1)];
      rem_b_r <= prod[31:0];
      n_b_r   <= n_b;
      frz_b_r <= (fr == 32'd0);
      ovf_b_r <= ovf_a_r;
      ctx_c_r <= ctx_b_r;
      lo_c_r  <= lo_b_r;
      p_c_r   <= 64'(hi_b_r - lo_b_r) * 64'(rem_b_r);
      n_c_r   <= n_b_r;
      frz_c_r <= frz_b_r;
      ovf_c_r <= ovf_b_r;
      ctx_d_r <= ctx_c_r;
      e_d_r   <= e_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_ctx   = ctx_d_r;
  assign out_e     = e_d_r;

endmodule

>>> rtl/core/afu_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on afu_pkg
module afu_div import afu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_NW-1:0] in_num,
  input  logic [DIV_DW-1:0] in_den,
  input  ctx_t              in_ctx,
  output logic              out_valid,
  output logic [DIV_QW-1:0] out_q,
  output ctx_t              out_ctx
);

  logic              v_r   [DIV_QW];
  logic [DIV_DW-1:0] rem_r [DIV_QW];
  logic [DIV_QW-1:0] nlo_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] q_r   [DIV_QW];
  ctx_t              ctx_r [DIV_QW];

  logic              v_i   [DIV_QW];
  logic [DIV_DW-1:0] rem_i [DIV_QW];
  logic [DIV_QW-1:0] nlo_i [DIV_QW];
  logic [DIV_DW-1:0] den_i [DIV_QW];
  logic [DIV_QW-1:0] q_i   [DIV_QW];
  ctx_t              ctx_i [DIV_QW];

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW-1:0] rem_nxt;
    logic [DIV_QW-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign v_i[s]   = in_valid;
      assign rem_i[s] = DIV_DW'(in_num[DIV_NW-1:DIV_QW]);
      assign nlo_i[s] = in_num[DIV_QW-1:0];
      assign den_i[s] = in_den;
      assign q_i[s]   = '0;
      assign ctx_i[s] = in_ctx;
    end else begin : g_next
      assign v_i[s]   = v_r[s-1];
      assign rem_i[s] = rem_r[s-1];
      assign nlo_i[s] = nlo_r[s-1];
      assign den_i[s] = den_r[s-1];
      assign q_i[s]   = q_r[s-1];
      assign ctx_i[s] = ctx_r[s-1];
    end

    always_comb begin
      trial   = {rem_i[s], nlo_i[s][DIV_QW-1-s]};
      ge      = trial >= {1'b0, den_i[s]};
      rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_i[s]}) : trial[DIV_DW-1:0];
      q_nxt   = q_i[s] | (DIV_QW'(ge) << (DIV_QW - 1 - s));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nlo_r[s] <= nlo_i[s];
        den_r[s] <= den_i[s];
        q_r[s]   <= q_nxt;
        ctx_r[s] <= ctx_i[s];
      end
    end
  end

  assign out_valid = v_r[DIV_QW-1];
  assign out_q     = q_r[DIV_QW-1];
  assign out_ctx   = ctx_r[DIV_QW-1];

endmodule

>>> rtl/core/afu_checker.sv
// port-level checks of the activation function unit, bound to the top level
// depends on activation_function_unit_defines.svh
`include "activation_function_unit_defines.svh"

module afu_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] out_result_out
);

  `AFU_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_result_out), "stalled result item changed or dropped")
  `AFU_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall, "reset left item valid or stall set")
  `AFU_ASSERT(a_skid_cause, clk, rst_n, in_stall |-> out_valid, "input stalled with no result item waiting")

endmodule

bind activation_function_unit afu_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_afu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_result_out(out_result_out)
);
